// ===== hdl/psnr_pkg.sv =====
// Shared types and constants for the PCM-to-stereo16 nearest-neighbor resampler.
package psnr_pkg;

  localparam int unsigned TARGET_RATE_DEF = 44100;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned PHASE_W    = 18;
  localparam int unsigned SAMPLE_W   = 16;

  localparam logic [PHASE_W-1:0] RATE_MIN   = 18'd1000;
  localparam logic [PHASE_W-1:0] RATE_MAX   = 18'd192000;
  localparam logic [PHASE_W-1:0] RATE_RESET = 18'd44100;

  localparam logic [1:0] CHANNELS_RESET     = 2'd2;
  localparam logic [1:0] SAMPLE_BYTES_RESET = 2'd2;

  // Format codes shared by both format registers
  localparam logic [1:0] FMT_ONE = 2'd1;
  localparam logic [1:0] FMT_TWO = 2'd2;

  typedef enum logic [1:0] {
    REG_CHANNELS     = 2'd0,
    REG_SAMPLE_BYTES = 2'd1,
    REG_SOURCE_RATE  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;   // input byte transfer this cycle
    logic advance;  // output transfer this cycle
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic frame_emit; // accepted byte completes a frame that yields output
    logic run_last;   // current output is the final one of its frame
  } sts_t;

endpackage

// ===== hdl/psnr_ctrl.sv =====
// Controller FSM: alternates between taking bytes and emitting a frame's outputs.
module psnr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  input  psnr_pkg::sts_t  sts_i,
  output psnr_pkg::cmd_t  cmd_o
);
  import psnr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    s_ready_o   = 1'b0;
    m_valid_o   = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
        if (s_valid_i && sts_i.frame_emit) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        m_valid_o     = 1'b1;
        cmd_o.advance = m_ready_i;
        if (m_ready_i && sts_i.run_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/psnr_dp.sv =====
// Datapath: config registers, frame assembly, sample conversion and phase stepping.
module psnr_dp #(
  parameter int unsigned TARGET_RATE = psnr_pkg::TARGET_RATE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psnr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [psnr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [7:0]                         in_byte_i,
  input  logic                               in_start_i,
  input  psnr_pkg::cmd_t                     cmd_i,
  output psnr_pkg::sts_t                     sts_o,
  output logic signed [psnr_pkg::SAMPLE_W-1:0] left_o,
  output logic signed [psnr_pkg::SAMPLE_W-1:0] right_o,
  output logic                               last_o
);
  import psnr_pkg::*;

  localparam logic [PHASE_W:0] TargetW = (PHASE_W+1)'(TARGET_RATE);

  logic [1:0]          chan_q, chan_d;
  logic [1:0]          sbytes_q, sbytes_d;
  logic [PHASE_W-1:0]  rate_q, rate_d;      // clamped source rate
  logic [1:0]          bidx_q, bidx_d;
  logic [7:0]          low_q, low_d;
  logic [SAMPLE_W-1:0] held_q, held_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [SAMPLE_W-1:0] outl_q, outl_d;
  logic [SAMPLE_W-1:0] outr_q, outr_d;

  logic                fmt_ok, mono, wide;
  logic [2:0]          frame_bytes;
  logic [1:0]          bidx_base, bidx_eff, bidx_inc, bidx_nxt;
  logic [1:0]          sample_no;
  logic [SAMPLE_W-1:0] sample;
  logic                sample_done, frame_done;
  logic [PHASE_W-1:0]  phase_base;
  logic                phase_low;
  logic [PHASE_W:0]    phase_sum;
  logic [PHASE_W:0]    base_minus;
  logic [PHASE_W:0]    sum_minus;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q   <= CHANNELS_RESET;
      sbytes_q <= SAMPLE_BYTES_RESET;
      rate_q   <= RATE_RESET;
      bidx_q   <= '0;
      low_q    <= '0;
      held_q   <= '0;
      phase_q  <= '0;
      outl_q   <= '0;
      outr_q   <= '0;
    end else begin
      chan_q   <= chan_d;
      sbytes_q <= sbytes_d;
      rate_q   <= rate_d;
      bidx_q   <= bidx_d;
      low_q    <= low_d;
      held_q   <= held_d;
      phase_q  <= phase_d;
      outl_q   <= outl_d;
      outr_q   <= outr_d;
    end
  end

  always_comb begin
    mono   = (chan_q == FMT_ONE);
    wide   = (sbytes_q == FMT_TWO);
    fmt_ok = (mono || chan_q == FMT_TWO) && (wide || sbytes_q == FMT_ONE);
    unique case ({mono, wide})
      2'b10:   frame_bytes = 3'd1;
      2'b01:   frame_bytes = 3'd4;
      default: frame_bytes = 3'd2;
    endcase

    bidx_base = in_start_i ? 2'd0 : bidx_q;
    bidx_eff  = ({1'b0, bidx_base} >= frame_bytes) ? 2'd0 : bidx_base;
    bidx_inc  = bidx_eff + 2'd1;
    bidx_nxt  = ({1'b0, bidx_inc} >= frame_bytes) ? 2'd0 : bidx_inc;

    if (!wide) begin
      sample      = {~in_byte_i[7], in_byte_i[6:0], 8'h00};
      sample_done = 1'b1;
      sample_no   = bidx_eff;
    end else begin
      sample      = {in_byte_i, low_q};
      sample_done = bidx_eff[0];
      sample_no   = {1'b0, bidx_eff[1]};
    end
    frame_done = sample_done && (mono || sample_no != 2'd0);

    phase_base = in_start_i ? '0 : phase_q;
    phase_low  = ({1'b0, phase_base} < TargetW);
    base_minus = {1'b0, phase_base} - TargetW;
    phase_sum  = {1'b0, phase_q} + {1'b0, rate_q};
    sum_minus  = phase_sum - TargetW;

    sts_o.frame_emit = fmt_ok && frame_done && phase_low;
    sts_o.run_last   = (phase_sum >= TargetW);

    chan_d   = chan_q;
    sbytes_d = sbytes_q;
    rate_d   = rate_q;
    bidx_d   = bidx_q;
    low_d    = low_q;
    held_d   = held_q;
    phase_d  = phase_q;
    outl_d   = outl_q;
    outr_d   = outr_q;

    if (cmd_i.accept) begin
      if (in_start_i) begin
        bidx_d  = '0;
        phase_d = '0;
      end
      if (fmt_ok) begin
        bidx_d = bidx_nxt;
        if (wide && !bidx_eff[0]) begin
          low_d = in_byte_i;
        end
        if (sample_done && !mono && sample_no == 2'd0) begin
          held_d = sample;
        end
        if (frame_done) begin
          if (phase_low) begin
            outl_d  = mono ? sample : held_q;
            outr_d  = sample;
            phase_d = phase_base;
          end else begin
            phase_d = base_minus[PHASE_W-1:0];
          end
        end
      end
    end else if (cmd_i.advance) begin
      phase_d = sts_o.run_last ? sum_minus[PHASE_W-1:0] : phase_sum[PHASE_W-1:0];
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CHANNELS: begin
          chan_d = cfg_data_i[1:0];
          bidx_d = '0;
        end
        REG_SAMPLE_BYTES: begin
          sbytes_d = cfg_data_i[1:0];
          bidx_d   = '0;
        end
        REG_SOURCE_RATE: begin
          if (cfg_data_i < RATE_MIN) begin
            rate_d = RATE_MIN;
          end else if (cfg_data_i > RATE_MAX) begin
            rate_d = RATE_MAX;
          end else begin
            rate_d = cfg_data_i;
          end
        end
        default: ;
      endcase
    end
  end

  assign left_o  = outl_q;
  assign right_o = outr_q;
  assign last_o  = sts_o.run_last;

endmodule

// ===== hdl/pcm_stereo16_nearest_resampler.sv =====
// Top level of the PCM byte stream to stereo 16-bit nearest-neighbor resampler.
// Takes one raw PCM byte per transfer (mono/stereo, 8-bit unsigned or
// 16-bit LE signed, set by config registers 0 and 1) and emits signed
// 16-bit stereo pairs resampled from source_rate (register 2, clamped to
// 1000..192000) to TARGET_RATE by nearest-lower picking. tuser on the input
// restarts frame assembly and phase. A byte that does not finish a frame,
// or finishes one that yields nothing, is just its byte transfer. A frame
// that yields outputs takes the byte transfer, then one output transfer
// per cycle while the phase accumulator is below TARGET_RATE; tlast marks
// the final output of a frame. Input is not taken while outputs of a frame
// are pending. Output cycles stretch with downstream backpressure.
// Config must be written only while the block is idle; a format write
// restarts frame assembly but keeps the phase.
module pcm_stereo16_nearest_resampler #(
  parameter int unsigned TARGET_RATE = psnr_pkg::TARGET_RATE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [psnr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [psnr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input byte stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // [7:0] data_byte
  input  logic                             s_axis_tuser_i,  // [0] buffer_start
  // stereo output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [31:0]                      m_axis_tdata_o,  // [15:0] left, [31:16] right
  output logic                             m_axis_tlast_o   // last_of_run
);
  import psnr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [SAMPLE_W-1:0] left, right;

  psnr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  psnr_dp #(
    .TARGET_RATE (TARGET_RATE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_start_i (s_axis_tuser_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .left_o     (left),
    .right_o    (right),
    .last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {right, left};

`ifndef ASSERT_OFF
  // input and output are never open in the same cycle
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid_i && s_axis_tready_o && m_axis_tvalid_o))
    else $error("input accepted while outputs pending");

  // a frame's run ends on tlast
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("output continued after tlast");

  // a run without tlast keeps emitting
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("output run ended without tlast");
`endif

endmodule
